/* hdl/bsub3d_pkg.sv */
package bsub3d_pkg;

   // Geometry of one item
   localparam int NUM_AXES  = 3;
   localparam int NUM_SLOTS = 2 * NUM_AXES;
   localparam int SLOT_BITS = 3;

   // Slab codes carried on the result tuser
   typedef enum logic [SLOT_BITS-1:0] {
      SLOT_X_BELOW = 3'd0,
      SLOT_X_ABOVE = 3'd1,
      SLOT_Y_BELOW = 3'd2,
      SLOT_Y_ABOVE = 3'd3,
      SLOT_Z_BELOW = 3'd4,
      SLOT_Z_ABOVE = 3'd5
   } slot_type;

   // Bit positions within the result tuser
   localparam int TUSER_SLOT_LSB  = 0;
   localparam int TUSER_EMPTY_BIT = SLOT_BITS;
   localparam int TUSER_BITS      = SLOT_BITS + 1;

endpackage

/* hdl/box_subtract_3d.sv */
// Channel  Dir  Ports                       Content
// req      in   req_tvalid/tready/tdata     grid box then cut box, twelve bounds
// rsp      out  rsp_tvalid/tready/tdata/    one remaining piece per transfer,
//               tuser/tlast                 slab code, empty flag, last of item
//
// An item passes three register stages (input, compare, piece build)
// and then the output register, which drives rsp.
// The piece-build stage hands one piece per cycle to the output register while rsp
// is not stalled, and takes the next item as the last of one to six pieces goes out.
// Reset is synchronous and clears the valid bits of every stage and the pending mask.
// A stall on rsp holds the output register; earlier stages keep filling
// until each holds an item, then req_tready falls.
module box_subtract_3d #(
   parameter int COORD_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // grid_x_lo, grid_x_hi, grid_y_lo, grid_y_hi, grid_z_lo, grid_z_hi,
   // cut_x_lo, cut_x_hi, cut_y_lo, cut_y_hi, cut_z_lo, cut_z_hi
   input  logic [((12*COORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // piece_x_lo, piece_x_hi, piece_y_lo, piece_y_hi, piece_z_lo, piece_z_hi
   output logic [((6*COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   // piece_slot [2:0], nothing_left [3]
   output logic [bsub3d_pkg::TUSER_BITS-1:0] rsp_tuser,
   output logic rsp_tlast
);
   import bsub3d_pkg::*;

   localparam int OUT_BITS = ((6*COORD_BITS+7)/8)*8;

   typedef logic [COORD_BITS-1:0] coord_type;

   // Stage 1: registered input
   logic      s1_vld_ff, s1_vld_in;
   coord_type s1_glo_ff [NUM_AXES];
   coord_type s1_ghi_ff [NUM_AXES];
   coord_type s1_clo_ff [NUM_AXES];
   coord_type s1_chi_ff [NUM_AXES];

   // Stage 2: bounds and compare flags
   logic      s2_vld_ff, s2_vld_in;
   coord_type s2_glo_ff [NUM_AXES];
   coord_type s2_ghi_ff [NUM_AXES];
   coord_type s2_clo_ff [NUM_AXES];
   coord_type s2_chi_ff [NUM_AXES];
   logic [NUM_AXES-1:0] s2_below_ff, s2_below_in;
   logic [NUM_AXES-1:0] s2_above_ff, s2_above_in;
   logic      s2_disjoint_ff, s2_disjoint_in;

   // Stage 3: built pieces and pending mask
   logic      s3_vld_ff, s3_vld_in;
   coord_type s3_lo_ff [NUM_SLOTS][NUM_AXES];
   coord_type s3_hi_ff [NUM_SLOTS][NUM_AXES];
   coord_type s3_lo_in [NUM_SLOTS][NUM_AXES];
   coord_type s3_hi_in [NUM_SLOTS][NUM_AXES];
   logic [NUM_SLOTS-1:0] s3_mask_ff, s3_mask_in, s3_mask_new;
   logic      s3_empty_ff, s3_empty_in;

   // Output register
   logic      rsp_vld_ff, rsp_vld_in;
   logic [6*COORD_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [SLOT_BITS-1:0]    rsp_slot_ff;
   logic      rsp_empty_ff, rsp_last_ff;

   // Handshake between stages
   logic out_load, s3_done, s3_take, s2_take, s1_take;
   logic [SLOT_BITS-1:0] pick;
   logic [NUM_SLOTS-1:0] mask_left;
   logic pick_last;

   assign out_load  = s3_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign s3_done   = out_load && pick_last;
   assign s3_take   = !s3_vld_ff || s3_done;
   assign s2_take   = !s2_vld_ff || s3_take;
   assign s1_take   = !s1_vld_ff || s2_take;
   assign req_tready = s1_take;

   // Stage 1: capture the request
   assign s1_vld_in = req_tvalid || !s1_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take && req_tvalid) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            s1_glo_ff[a] <= req_tdata[(2*a)*COORD_BITS +: COORD_BITS];
            s1_ghi_ff[a] <= req_tdata[(2*a+1)*COORD_BITS +: COORD_BITS];
            s1_clo_ff[a] <= req_tdata[(6+2*a)*COORD_BITS +: COORD_BITS];
            s1_chi_ff[a] <= req_tdata[(7+2*a)*COORD_BITS +: COORD_BITS];
         end
      end
   end

   // Stage 2: compare each axis
   always_comb begin
      s2_disjoint_in = 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
         s2_below_in[a] = s1_glo_ff[a] < s1_clo_ff[a];
         s2_above_in[a] = s1_ghi_ff[a] > s1_chi_ff[a];
         if (s1_glo_ff[a] > s1_chi_ff[a] || s1_ghi_ff[a] < s1_clo_ff[a]) begin
            s2_disjoint_in = 1'b1;
         end
      end
   end

   assign s2_vld_in = s1_vld_ff || !s2_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_take && s1_vld_ff) begin
         s2_glo_ff      <= s1_glo_ff;
         s2_ghi_ff      <= s1_ghi_ff;
         s2_clo_ff      <= s1_clo_ff;
         s2_chi_ff      <= s1_chi_ff;
         s2_below_ff    <= s2_below_in;
         s2_above_ff    <= s2_above_in;
         s2_disjoint_ff <= s2_disjoint_in;
      end
   end

   // Stage 3: build all six slabs, core clipped by earlier axes
   always_comb begin
      coord_type cur_lo [NUM_AXES];
      coord_type cur_hi [NUM_AXES];
      for (int b = 0; b < NUM_AXES; b++) begin
         cur_lo[b] = s2_below_ff[b] ? s2_clo_ff[b] : s2_glo_ff[b];
         cur_hi[b] = s2_above_ff[b] ? s2_chi_ff[b] : s2_ghi_ff[b];
      end
      for (int a = 0; a < NUM_AXES; a++) begin
         for (int b = 0; b < NUM_AXES; b++) begin
            if (b < a) begin
               s3_lo_in[2*a][b]   = cur_lo[b];
               s3_hi_in[2*a][b]   = cur_hi[b];
               s3_lo_in[2*a+1][b] = cur_lo[b];
               s3_hi_in[2*a+1][b] = cur_hi[b];
            end else if (b > a) begin
               s3_lo_in[2*a][b]   = s2_glo_ff[b];
               s3_hi_in[2*a][b]   = s2_ghi_ff[b];
               s3_lo_in[2*a+1][b] = s2_glo_ff[b];
               s3_hi_in[2*a+1][b] = s2_ghi_ff[b];
            end else begin
               s3_lo_in[2*a][b]   = s2_glo_ff[b];
               s3_hi_in[2*a][b]   = s2_clo_ff[b] - coord_type'(1);
               s3_lo_in[2*a+1][b] = s2_chi_ff[b] + coord_type'(1);
               s3_hi_in[2*a+1][b] = s2_ghi_ff[b];
            end
         end
         s3_mask_new[2*a]   = s2_below_ff[a];
         s3_mask_new[2*a+1] = s2_above_ff[a];
      end
      s3_empty_in = 1'b0;
      s3_mask_in  = s3_mask_new;
      // Disjoint: pass the grid box as a single piece in the first slot
      if (s2_disjoint_ff) begin
         s3_mask_in = NUM_SLOTS'(1);
         for (int b = 0; b < NUM_AXES; b++) begin
            s3_lo_in[0][b] = s2_glo_ff[b];
            s3_hi_in[0][b] = s2_ghi_ff[b];
         end
      end else if (s3_mask_new == '0) begin
         // Fully covered: one zero box flagged empty
         s3_mask_in  = NUM_SLOTS'(1);
         s3_empty_in = 1'b1;
         for (int b = 0; b < NUM_AXES; b++) begin
            s3_lo_in[0][b] = '0;
            s3_hi_in[0][b] = '0;
         end
      end
   end

   assign s3_vld_in = s2_vld_ff || !s3_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s3_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_mask_ff <= '0;
      end else if (s3_take) begin
         s3_mask_ff <= s2_vld_ff ? s3_mask_in : '0;
      end else if (out_load) begin
         s3_mask_ff <= mask_left;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_take && s2_vld_ff) begin
         s3_lo_ff    <= s3_lo_in;
         s3_hi_ff    <= s3_hi_in;
         s3_empty_ff <= s3_empty_in;
      end
   end

   // Pick the lowest pending slab
   always_comb begin
      pick = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (s3_mask_ff[i]) begin
            pick = SLOT_BITS'(i);
         end
      end
      mask_left       = s3_mask_ff;
      mask_left[pick] = 1'b0;
      pick_last       = (mask_left == '0);
      for (int b = 0; b < NUM_AXES; b++) begin
         rsp_data_in[(2*b)*COORD_BITS +: COORD_BITS]   = s3_lo_ff[pick][b];
         rsp_data_in[(2*b+1)*COORD_BITS +: COORD_BITS] = s3_hi_ff[pick][b];
      end
   end

   // Output register: load on each transfer slot
   assign rsp_vld_in = s3_vld_ff || (rsp_vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_slot_ff  <= s3_empty_ff ? SLOT_X_BELOW : pick;
         rsp_empty_ff <= s3_empty_ff;
         rsp_last_ff  <= pick_last;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = OUT_BITS'(rsp_data_ff);
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser[TUSER_SLOT_LSB +: SLOT_BITS] = rsp_slot_ff;
   assign rsp_tuser[TUSER_EMPTY_BIT]             = rsp_empty_ff;

   // Checks
   a_empty_is_single_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_empty_ff |-> rsp_last_ff && rsp_data_ff == '0)
      else $error("empty result not a single zero box");

   a_busy_has_pieces: assert property (@(posedge clock) disable iff (reset)
      s3_vld_ff |-> s3_mask_ff != '0)
      else $error("piece stage valid with nothing pending");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> rsp_slot_ff <= SLOT_Z_ABOVE)
      else $error("slab code out of range");

   a_mask_shrinks: assert property (@(posedge clock) disable iff (reset)
      out_load && !pick_last |=> s3_vld_ff && s3_mask_ff == $past(mask_left))
      else $error("pending mask lost a slab");

endmodule

/* tb/box_subtract_3d_checker.sv */
module box_subtract_3d_checker #(
   parameter int COORD_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   // grid_x_lo, grid_x_hi, grid_y_lo, grid_y_hi, grid_z_lo, grid_z_hi,
   // cut_x_lo, cut_x_hi, cut_y_lo, cut_y_hi, cut_z_lo, cut_z_hi
   input  logic [((12*COORD_BITS+7)/8)*8-1:0] req_tdata,
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   // piece_x_lo, piece_x_hi, piece_y_lo, piece_y_hi, piece_z_lo, piece_z_hi
   input  logic [((6*COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   // piece_slot [2:0], nothing_left [3]
   input  logic [bsub3d_pkg::TUSER_BITS-1:0] rsp_tuser,
   input  logic rsp_tlast,
   input  logic run_done,
   output int   mismatch_count,
   output int   pending_count,
   output int   pieces_checked,
   output int   covered_seen
);
   import bsub3d_pkg::*;

   localparam int REQ_W = ((12*COORD_BITS+7)/8)*8;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type [NUM_AXES-1:0] lo;
      coord_type [NUM_AXES-1:0] hi;
      slot_type                 slot;
      logic                     empty;
      logic                     last;
   } piece_type;

   piece_type remaining_pieces[$];
   logic      leftover_checked;

   // Print one line per failure and count it
   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      mismatch_count++;
   endtask

   // Clip the grid box against the cut box axis by axis and queue the pieces left over
   function automatic void predict_pieces(input logic [REQ_W-1:0] word);
      coord_type [NUM_AXES-1:0] g_lo;
      coord_type [NUM_AXES-1:0] g_hi;
      coord_type [NUM_AXES-1:0] c_lo;
      coord_type [NUM_AXES-1:0] c_hi;
      piece_type                piece;
      piece_type                found[NUM_SLOTS];
      int                       count;
      logic                     apart;
      count = 0;
      apart = 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
         g_lo[a] = word[(2*a)*COORD_BITS +: COORD_BITS];
         g_hi[a] = word[(2*a+1)*COORD_BITS +: COORD_BITS];
         c_lo[a] = word[(6+2*a)*COORD_BITS +: COORD_BITS];
         c_hi[a] = word[(7+2*a)*COORD_BITS +: COORD_BITS];
         if (g_lo[a] > c_hi[a] || g_hi[a] < c_lo[a]) apart = 1'b1;
      end
      if (apart) begin
         // no shared cell: the grid box passes through whole
         piece       = '0;
         piece.lo    = g_lo;
         piece.hi    = g_hi;
         piece.slot  = SLOT_X_BELOW;
         found[0]    = piece;
         count       = 1;
      end else begin
         for (int a = 0; a < NUM_AXES; a++) begin
            // slab below the cut, then shrink the core
            if (g_lo[a] < c_lo[a]) begin
               piece       = '0;
               piece.lo    = g_lo;
               piece.hi    = g_hi;
               piece.hi[a] = c_lo[a] - 1'b1;
               piece.slot  = slot_type'(2 * a);
               found[count] = piece;
               count++;
               g_lo[a] = c_lo[a];
            end
            // slab above the cut, then shrink the core
            if (g_hi[a] > c_hi[a]) begin
               piece       = '0;
               piece.lo    = g_lo;
               piece.hi    = g_hi;
               piece.lo[a] = c_hi[a] + 1'b1;
               piece.slot  = slot_type'(2 * a + 1);
               found[count] = piece;
               count++;
               g_hi[a] = c_hi[a];
            end
         end
         // grid fully covered: one empty marker
         if (count == 0) begin
            piece       = '0;
            piece.slot  = SLOT_X_BELOW;
            piece.empty = 1'b1;
            found[0]    = piece;
            count       = 1;
         end
      end
      found[count-1].last = 1'b1;
      for (int i = 0; i < count; i++) remaining_pieces = {remaining_pieces, found[i]};
   endfunction

   // Compare one result transfer with the oldest predicted piece
   task automatic check_piece();
      piece_type seen;
      piece_type want;
      for (int a = 0; a < NUM_AXES; a++) begin
         seen.lo[a] = rsp_tdata[(2*a)*COORD_BITS +: COORD_BITS];
         seen.hi[a] = rsp_tdata[(2*a+1)*COORD_BITS +: COORD_BITS];
      end
      seen.slot  = slot_type'(rsp_tuser[TUSER_SLOT_LSB +: SLOT_BITS]);
      seen.empty = rsp_tuser[TUSER_EMPTY_BIT];
      seen.last  = rsp_tlast;
      pieces_checked++;
      if (remaining_pieces.size() == 0) begin
         report_mismatch($sformatf("unexpected piece, slot %0d", seen.slot));
         return;
      end
      want = remaining_pieces.pop_front();
      if (want.empty) covered_seen++;
      for (int a = 0; a < NUM_AXES; a++) begin
         if (seen.lo[a] !== want.lo[a])
            report_mismatch($sformatf("axis %0d lo: got %0d, expected %0d",
                                      a, seen.lo[a], want.lo[a]));
         if (seen.hi[a] !== want.hi[a])
            report_mismatch($sformatf("axis %0d hi: got %0d, expected %0d",
                                      a, seen.hi[a], want.hi[a]));
      end
      if (seen.slot !== want.slot)
         report_mismatch($sformatf("slot: got %0d, expected %0d", seen.slot, want.slot));
      if (seen.empty !== want.empty)
         report_mismatch($sformatf("nothing_left: got %b, expected %b",
                                   seen.empty, want.empty));
      if (seen.last !== want.last)
         report_mismatch($sformatf("tlast: got %b, expected %b", seen.last, want.last));
   endtask

   // Watch both channels on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         remaining_pieces.delete();
         leftover_checked <= 1'b0;
         mismatch_count    = 0;
         pending_count    <= 0;
         pieces_checked    = 0;
         covered_seen      = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_piece();
         if (req_tvalid && req_tready) predict_pieces(req_tdata);
         if (run_done && !leftover_checked) begin
            leftover_checked <= 1'b1;
            if (remaining_pieces.size() != 0)
               report_mismatch($sformatf("%0d predicted pieces never arrived",
                                         remaining_pieces.size()));
         end
         pending_count <= remaining_pieces.size();
      end
   end

endmodule

/* tb/tb_box_subtract_3d.sv */
module tb_box_subtract_3d;
   import bsub3d_pkg::*;

   localparam int COORD_BITS     = 16;
   localparam int REQ_W          = ((12*COORD_BITS+7)/8)*8;
   localparam int RSP_W          = ((6*COORD_BITS+7)/8)*8;
   localparam int ITEMS_PER_LEG  = 84;
   localparam int TAIL_CYCLES    = 12;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int COORD_MAX      = (1 << COORD_BITS) - 1;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [REQ_W-1:0]      req_word_type;

   typedef enum {
      PAIR_OVERLAP,
      PAIR_INSIDE,
      PAIR_COVERED,
      PAIR_APART,
      PAIR_NOISE
   } pair_kind_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   req_word_type          req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic [TUSER_BITS-1:0] rsp_tuser;
   logic                  rsp_tlast;
   logic                  run_done;

   int mismatch_count;
   int pending_count;
   int pieces_checked;
   int covered_seen;
   int items_sent;
   int send_gap_pct;
   int sink_stall_pct;
   int quiet_cycles;

   box_subtract_3d #(
      .COORD_BITS (COORD_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   box_subtract_3d_checker #(
      .COORD_BITS (COORD_BITS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .run_done       (run_done),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .pieces_checked (pieces_checked),
      .covered_seen   (covered_seen)
   );

   always #6 clock = ~clock;

   // Stall the result channel at the current rate
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Pack twelve bounds, grid x lo in the lowest bits
   function automatic req_word_type pack_pair(
      input int unsigned gx0, gx1, gy0, gy1, gz0, gz1,
      input int unsigned cx0, cx1, cy0, cy1, cz0, cz1
   );
      return {coord_type'(cz1), coord_type'(cz0), coord_type'(cy1), coord_type'(cy0),
              coord_type'(cx1), coord_type'(cx0), coord_type'(gz1), coord_type'(gz0),
              coord_type'(gy1), coord_type'(gy0), coord_type'(gx1), coord_type'(gx0)};
   endfunction

   // Build a random pair of boxes of the given shape
   function automatic req_word_type build_pair(input pair_kind_type kind);
      req_word_type  word;
      pair_kind_type axis_kind;
      int unsigned   base;
      int unsigned   apart_axis;
      coord_type     g_lo, g_hi, c_lo, c_hi;
      word       = '0;
      apart_axis = $urandom_range(NUM_AXES - 1);
      for (int a = 0; a < NUM_AXES; a++) begin
         axis_kind = kind;
         if (kind == PAIR_APART && a != apart_axis) axis_kind = PAIR_OVERLAP;
         base = $urandom_range(COORD_MAX - 96);
         g_lo = coord_type'(base + $urandom_range(16));
         g_hi = coord_type'(g_lo + $urandom_range(16));
         unique case (axis_kind)
            PAIR_OVERLAP: begin
               c_lo = coord_type'(base + $urandom_range(g_hi - base));
               c_hi = coord_type'(((c_lo > g_lo) ? c_lo : g_lo) + $urandom_range(24));
            end
            PAIR_INSIDE: begin
               g_hi = coord_type'(g_lo + 2 + $urandom_range(16));
               c_lo = coord_type'(g_lo + 1 + $urandom_range(g_hi - g_lo - 2));
               c_hi = coord_type'(c_lo + $urandom_range(g_hi - 1 - c_lo));
            end
            PAIR_COVERED: begin
               c_lo = coord_type'(g_lo - $urandom_range(g_lo - base));
               c_hi = coord_type'(g_hi + $urandom_range(16));
            end
            PAIR_APART: begin
               if ($urandom_range(1) == 1 && g_lo >= 9) begin
                  c_hi = coord_type'(g_lo - 1 - $urandom_range(8));
                  c_lo = coord_type'($urandom_range(c_hi));
               end else begin
                  c_lo = coord_type'(g_hi + 1 + $urandom_range(8));
                  c_hi = coord_type'(c_lo + $urandom_range(8));
               end
            end
            default: begin
               g_lo = coord_type'($urandom_range(COORD_MAX));
               g_hi = coord_type'($urandom_range(COORD_MAX));
               c_lo = coord_type'($urandom_range(COORD_MAX));
               c_hi = coord_type'($urandom_range(COORD_MAX));
            end
         endcase
         word[(2*a)*COORD_BITS +: COORD_BITS]   = g_lo;
         word[(2*a+1)*COORD_BITS +: COORD_BITS] = g_hi;
         word[(6+2*a)*COORD_BITS +: COORD_BITS] = c_lo;
         word[(7+2*a)*COORD_BITS +: COORD_BITS] = c_hi;
      end
      return word;
   endfunction

   // Half overlapping pairs, the rest inside, covered, apart or raw noise
   function automatic pair_kind_type pick_kind();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 50) return PAIR_OVERLAP;
      if (roll < 65) return PAIR_INSIDE;
      if (roll < 75) return PAIR_COVERED;
      if (roll < 85) return PAIR_APART;
      return PAIR_NOISE;
   endfunction

   // Offer one box pair, idling first at the current rate; returns at a falling edge
   task automatic send_item(input req_word_type word);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      @(negedge clock);
   endtask

   // Hold off until every predicted piece has come back
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      run_done       = 1'b0;
      items_sent     = 0;
      send_gap_pct   = 19;
      sink_stall_pct = 46;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes, touching faces, inverted bounds, each axis's slab pair alone
      send_item(pack_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_item(pack_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                          COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      send_item(pack_pair(0, COORD_MAX, 0, COORD_MAX, 0, COORD_MAX,
                          0, COORD_MAX, 0, COORD_MAX, 0, COORD_MAX));
      send_item(pack_pair(0, COORD_MAX, 0, COORD_MAX, 0, COORD_MAX,
                          1, COORD_MAX - 1, 1, COORD_MAX - 1, 1, COORD_MAX - 1));
      send_item(pack_pair(0, COORD_MAX, 0, COORD_MAX, 0, COORD_MAX, 0, 0, 0, 0, 0, 0));
      send_item(pack_pair(0, COORD_MAX, 0, COORD_MAX, 0, COORD_MAX,
                          COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      send_item(pack_pair(0, 10, 0, 10, 0, 10, 11, 20, 0, 10, 0, 10));
      send_item(pack_pair(5, 9, 5, 9, 100, 200, 0, 20, 0, 20, 50, 99));
      send_item(pack_pair(COORD_MAX, COORD_MAX, 0, 5, 0, 5, 0, COORD_MAX - 1, 0, 5, 0, 5));
      send_item(pack_pair(0, 10, 0, 10, 0, 10, 10, 20, 0, 10, 0, 10));
      send_item(pack_pair(20, 10, 0, 10, 0, 10, 5, 30, 0, 10, 0, 10));
      send_item(pack_pair(0, 40, 0, 40, 0, 40, 30, 5, 0, 40, 0, 40));
      send_item(pack_pair(40, 2, 9, 3, 0, 40, 30, 5, 4, 1, 0, 40));
      send_item(pack_pair(10, 20, 10, 20, 10, 20, 10, 20, 10, 20, 10, 20));
      send_item(pack_pair(10, 20, 10, 20, 10, 20, 15, 15, 15, 15, 15, 15));
      send_item(pack_pair(10, 20, 0, 50, 10, 20, 0, 30, 20, 30, 0, 30));
      send_item(pack_pair(10, 20, 10, 20, 0, 50, 0, 30, 0, 30, 20, 30));
      send_item(pack_pair(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                          16'h5556, 16'hAAA9, 16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF));
      wait_for_drain();

      // Random legs: receiver-heavy stalls, then sender-heavy gaps, then full rate
      for (int leg = 0; leg < 3; leg++) begin
         send_gap_pct   = (leg == 0) ? 19 : (leg == 1) ? 46 : 0;
         sink_stall_pct = (leg == 0) ? 46 : (leg == 1) ? 19 : 0;
         for (int i = 0; i < ITEMS_PER_LEG; i++) begin
            send_item(build_pair(pick_kind()));
            if ($urandom_range(29) == 0) wait_for_drain();
         end
         wait_for_drain();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      run_done <= 1'b1;
      repeat (2) @(negedge clock);

      $display("Sent %0d box pairs: extremes, touching faces, inverted bounds, disjoint,",
               items_sent);
      $display("covered and six-slab cases; %0d pieces checked, %0d fully covered",
               pieces_checked, covered_seen);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
